// ----- hw/rtl/dsparse_pkg.sv -----
// Shared types, character codes and constants of the angle string parser.
package dsparse_pkg;

  // Configuration register indexes
  localparam logic [1:0] CFG_IDX_KIND = 2'd0;
  localparam logic [1:0] CFG_IDX_MAX  = 2'd1;
  localparam logic [1:0] CFG_IDX_MARK = 2'd2;
  localparam int unsigned CFG_W = 19;

  // Coordinate kinds
  localparam logic [1:0] KIND_PLAIN = 2'd0;
  localparam logic [1:0] KIND_LAT   = 2'd1;
  localparam logic [1:0] KIND_LON   = 2'd2;

  // Magnitude limits, thousandths of a degree
  localparam logic [18:0] LIMIT_LAT   = 19'd90000;
  localparam logic [18:0] LIMIT_LON   = 19'd180000;
  localparam logic [18:0] MAX_RST_VAL = 19'd360000;
  localparam logic [7:0]  MARK_RST_VAL = 8'd248;

  // Part index values
  localparam logic [1:0] PART_DEG = 2'd0;
  localparam logic [1:0] PART_MIN = 2'd1;
  localparam logic [1:0] PART_SEC = 2'd2;

  // Character codes
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_QUOTE  = 8'h27;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_UP_O   = 8'h4F;
  localparam logic [7:0] CH_LOW_O  = 8'h6F;
  localparam logic [7:0] CH_UP_N   = 8'h4E;
  localparam logic [7:0] CH_UP_S   = 8'h53;
  localparam logic [7:0] CH_UP_E   = 8'h45;
  localparam logic [7:0] CH_UP_W   = 8'h57;
  localparam logic [7:0] CH_LOW_A  = 8'h61;
  localparam logic [7:0] CH_LOW_Z  = 8'h7A;
  localparam logic [7:0] CASE_OFFSET = 8'd32;

  // Arithmetic constants
  localparam logic [9:0]  SEXA_MAX   = 10'd59;
  localparam logic [19:0] MILLI      = 20'd1000;
  // floor(5*t/18) = (t * RECIP) >> RECIP_SHIFT for t below 4096
  localparam logic [16:0] RECIP       = 17'd72820;
  localparam int unsigned RECIP_SHIFT = 18;

  // Running parse state of one string
  typedef struct packed {
    logic [1:0] part;
    logic [1:0] digits;
    logic [9:0] deg;
    logic [9:0] mins;
    logic [9:0] secs;
    logic       dec;
    logic [1:0] dec_left;
    logic       neg;
    logic       failed;
    logic       at_start;
    logic       term;
  } parse_state_t;

  localparam parse_state_t STATE_CLEAR = '{
    part:     PART_DEG,
    digits:   2'd0,
    deg:      10'd0,
    mins:     10'd0,
    secs:     10'd0,
    dec:      1'b0,
    dec_left: 2'd0,
    neg:      1'b0,
    failed:   1'b0,
    at_start: 1'b1,
    term:     1'b0
  };

  // Configuration registers
  typedef struct packed {
    logic [1:0]  coord_kind;
    logic [18:0] max_millideg;
    logic [7:0]  degree_mark;
  } cfg_t;

endpackage

// ----- hw/rtl/degree_string_parser.sv -----
// Top level of the angle string parser: input register, parse state, evaluation.
//
//  channel   dir  handshake              payload
//  s_axis    in   tvalid/tready          tdata[7:0] char_code, tlast last_char
//  m_axis    out  tvalid/tready          tdata[19:0] millidegrees, tuser[0] bad_form
//  cfg       in   cfg_we_i (no wait)     cfg_idx_i register index, cfg_data_i value
//
// One character a cycle while the output is not stalled; the state update is a
// single pass between the input register and the parse state. From its final character on,
// a result passes the input, snapshot, evaluation and output registers in turn.
// Reset clears the parse state and loads the register defaults.
// A stalled output holds the whole pipeline; the input register still takes
// one transaction while it is empty.
module degree_string_parser (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // character stream
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [7:0]                   s_axis_tdata,  // [7:0] char_code
  input  logic                         s_axis_tlast,
  // result stream
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  output logic [23:0]                  m_axis_tdata,  // [19:0] millidegrees, rest zero
  output logic [0:0]                   m_axis_tuser,  // [0] bad_form
  // configuration writes
  input  logic                         cfg_we_i,
  input  logic [1:0]                   cfg_idx_i,
  input  logic [dsparse_pkg::CFG_W-1:0] cfg_data_i
);

  dsparse_pkg::cfg_t         cfg_q;
  dsparse_pkg::parse_state_t state_q, step_state;
  dsparse_pkg::parse_state_t snap_q;
  logic                      snap_valid_q;
  logic                      in_valid_q;
  logic [7:0]                char_q;
  logic                      last_q;
  logic                      adv;
  logic                      res_valid;
  logic [19:0]               millideg;
  logic                      bad;

  // pipeline moves when the output register is free or being emptied
  assign adv           = !res_valid || m_axis_tready;
  assign s_axis_tready = !in_valid_q || adv;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.coord_kind   <= dsparse_pkg::KIND_PLAIN;
      cfg_q.max_millideg <= dsparse_pkg::MAX_RST_VAL;
      cfg_q.degree_mark  <= dsparse_pkg::MARK_RST_VAL;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        dsparse_pkg::CFG_IDX_KIND: cfg_q.coord_kind   <= cfg_data_i[1:0];
        dsparse_pkg::CFG_IDX_MAX:  cfg_q.max_millideg <= cfg_data_i[18:0];
        dsparse_pkg::CFG_IDX_MARK: cfg_q.degree_mark  <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready) begin
      char_q <= s_axis_tdata;
      last_q <= s_axis_tlast;
    end
  end

  dsparse_step u_step (
    .state_i (state_q),
    .cfg_i   (cfg_q),
    .char_i  (char_q),
    .last_i  (last_q),
    .state_o (step_state)
  );

  // Parse state; cleared after each final character
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= dsparse_pkg::STATE_CLEAR;
      snap_valid_q <= 1'b0;
    end else if (adv) begin
      snap_valid_q <= in_valid_q && last_q;
      if (in_valid_q) begin
        state_q <= last_q ? dsparse_pkg::STATE_CLEAR : step_state;
      end
    end
  end

  // Snapshot of the finished string for evaluation
  always_ff @(posedge clk_i) begin
    if (adv) begin
      snap_q <= step_state;
    end
  end

  dsparse_eval u_eval (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .adv_i        (adv),
    .snap_valid_i (snap_valid_q),
    .snap_i       (snap_q),
    .cfg_i        (cfg_q),
    .res_valid_o  (res_valid),
    .millideg_o   (millideg),
    .bad_o        (bad)
  );

  assign m_axis_tvalid   = res_valid;
  assign m_axis_tdata    = {4'd0, millideg};
  assign m_axis_tuser[0] = bad;

endmodule

// ----- hw/rtl/dsparse_step.sv -----
// Per-character parse state update of the angle string parser.
module dsparse_step (
  input  dsparse_pkg::parse_state_t state_i,
  input  dsparse_pkg::cfg_t         cfg_i,
  input  logic [7:0]                char_i,
  input  logic                      last_i,
  output dsparse_pkg::parse_state_t state_o
);

  function automatic logic is_digit(logic [7:0] c);
    return c inside {[dsparse_pkg::CH_ZERO : dsparse_pkg::CH_NINE]};
  endfunction

  // Append one decimal digit to the current part
  function automatic dsparse_pkg::parse_state_t add_digit(dsparse_pkg::parse_state_t s,
                                                          logic [7:0] c);
    dsparse_pkg::parse_state_t r;
    logic [9:0] d;
    r = s;
    d = {6'd0, c[3:0]};
    case (s.part)
      dsparse_pkg::PART_DEG: r.deg  = 10'(s.deg * 10'd10) + d;
      dsparse_pkg::PART_MIN: r.mins = 10'(s.mins * 10'd10) + d;
      default:               r.secs = 10'(s.secs * 10'd10) + d;
    endcase
    r.digits = s.digits + 2'd1;
    if (s.dec && (s.dec_left != 2'd0)) begin
      r.dec_left = s.dec_left - 2'd1;
    end
    return r;
  endfunction

  // Character after a terminated or full part: next part or suffix letter
  function automatic dsparse_pkg::parse_state_t follow_on(dsparse_pkg::parse_state_t s,
                                                          logic [7:0] c, logic last,
                                                          logic [1:0] kind);
    dsparse_pkg::parse_state_t r;
    logic [7:0] u;
    r = s;
    u = c;
    if (is_digit(c)) begin
      if ((s.dec && (s.dec_left == 2'd0)) || (s.part >= dsparse_pkg::PART_SEC)) begin
        r.failed = 1'b1;
      end else begin
        r.part   = s.part + 2'd1;
        r.digits = 2'd0;
        r.term   = 1'b0;
        r = add_digit(r, c);
      end
    end else if (!last) begin
      r.failed = 1'b1;
    end else begin
      if (c inside {[dsparse_pkg::CH_LOW_A : dsparse_pkg::CH_LOW_Z]}) begin
        u = c - dsparse_pkg::CASE_OFFSET;
      end
      if ((u == dsparse_pkg::CH_UP_N) && (kind == dsparse_pkg::KIND_LAT)) begin
        r.neg = s.neg;
      end else if ((u == dsparse_pkg::CH_UP_S) && (kind == dsparse_pkg::KIND_LAT)) begin
        r.neg = !s.neg;
      end else if ((u == dsparse_pkg::CH_UP_E) && (kind == dsparse_pkg::KIND_LON)) begin
        r.neg = s.neg;
      end else if ((u == dsparse_pkg::CH_UP_W) && (kind == dsparse_pkg::KIND_LON)) begin
        r.neg = !s.neg;
      end else begin
        r.failed = 1'b1;
      end
    end
    return r;
  endfunction

  // Take one character; an earlier error freezes the state
  always_comb begin
    dsparse_pkg::parse_state_t r;
    logic proceed;
    r = state_i;
    proceed = 1'b1;
    if (!state_i.failed) begin
      // optional sign at the very start
      if (state_i.at_start) begin
        r.at_start = 1'b0;
        if (char_i == dsparse_pkg::CH_MINUS) begin
          r.neg   = 1'b1;
          proceed = 1'b0;
        end else if (char_i == dsparse_pkg::CH_PLUS) begin
          proceed = 1'b0;
        end
      end
      if (proceed) begin
        if ((r.part == dsparse_pkg::PART_DEG) && (r.digits == 2'd0)) begin
          if (!is_digit(char_i)) r.failed = 1'b1;
          else                   r = add_digit(r, char_i);
        end else if (r.term) begin
          r = follow_on(r, char_i, last_i, cfg_i.coord_kind);
        end else if (is_digit(char_i) && (r.digits < 2'd3)) begin
          r = add_digit(r, char_i);
        end else if ((r.part == dsparse_pkg::PART_DEG) && (char_i == dsparse_pkg::CH_DOT)) begin
          r.dec      = 1'b1;
          r.dec_left = 2'd3;
          r.term     = 1'b1;
        end else if ((r.part == dsparse_pkg::PART_DEG) &&
                     ((char_i == dsparse_pkg::CH_LOW_O) || (char_i == dsparse_pkg::CH_UP_O) ||
                      (char_i == cfg_i.degree_mark))) begin
          r.term = 1'b1;
        end else if ((r.part == dsparse_pkg::PART_MIN) && (char_i == dsparse_pkg::CH_QUOTE) &&
                     !r.dec) begin
          r.term = 1'b1;
        end else if ((r.part != dsparse_pkg::PART_DEG) && (r.part != dsparse_pkg::PART_MIN) &&
                     (char_i == dsparse_pkg::CH_DQUOTE) && !r.dec) begin
          r.term = 1'b1;
        end else begin
          r = follow_on(r, char_i, last_i, cfg_i.coord_kind);
        end
      end
    end
    state_o = r;
  end

endmodule

// ----- hw/rtl/dsparse_eval.sv -----
// Two-stage evaluation of a finished string into millidegrees and error flag.
module dsparse_eval (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      adv_i,
  input  logic                      snap_valid_i,
  input  dsparse_pkg::parse_state_t snap_i,
  input  dsparse_pkg::cfg_t         cfg_i,
  output logic                      res_valid_o,
  output logic [19:0]               millideg_o,
  output logic                      bad_o
);

  typedef struct packed {
    logic [19:0] deg_k;
    logic [20:0] addend;
    logic [18:0] limit;
    logic        neg;
    logic        bad;
  } mid_t;

  mid_t        mid_d, mid_q;
  logic        mid_valid_q;
  logic        res_valid_q;
  logic [19:0] millideg_d, millideg_q;
  logic        bad_d, bad_q;

  // First stage: checks, limit, scaled parts and the reciprocal multiply
  always_comb begin
    logic [19:0] frac;
    logic [11:0] t;
    logic [28:0] prod;
    mid_d.bad = snap_i.failed ||
                ((snap_i.part == dsparse_pkg::PART_DEG) && (snap_i.digits == 2'd0)) ||
                (!snap_i.dec && ((snap_i.mins > dsparse_pkg::SEXA_MAX) ||
                                 (snap_i.secs > dsparse_pkg::SEXA_MAX)));
    case (cfg_i.coord_kind)
      dsparse_pkg::KIND_PLAIN: mid_d.limit = cfg_i.max_millideg;
      dsparse_pkg::KIND_LAT:   mid_d.limit = dsparse_pkg::LIMIT_LAT;
      dsparse_pkg::KIND_LON:   mid_d.limit = dsparse_pkg::LIMIT_LON;
      default: begin
        mid_d.limit = 19'd0;
        mid_d.bad   = 1'b1;
      end
    endcase
    mid_d.neg   = snap_i.neg;
    mid_d.deg_k = 20'({10'd0, snap_i.deg} * dsparse_pkg::MILLI);
    // fraction digits scaled by the missing places
    case (snap_i.dec_left)
      2'd0:    frac = {10'd0, snap_i.mins};
      2'd1:    frac = 20'({10'd0, snap_i.mins} * 20'd10);
      2'd2:    frac = 20'({10'd0, snap_i.mins} * 20'd100);
      default: frac = 20'({10'd0, snap_i.mins} * 20'd1000);
    endcase
    // minutes and seconds: (1000 * t) / 3600 = 5t / 18
    t    = 12'({6'd0, snap_i.mins[5:0]} * 12'd60) + {6'd0, snap_i.secs[5:0]};
    prod = 29'({17'd0, t} * {12'd0, dsparse_pkg::RECIP});
    if (snap_i.dec) mid_d.addend = {1'b0, frac};
    else            mid_d.addend = {10'd0, prod[28:dsparse_pkg::RECIP_SHIFT]};
  end

  // Second stage: sum, limit compare, sign
  always_comb begin
    logic [20:0] sum;
    sum   = {1'b0, mid_q.deg_k} + mid_q.addend;
    bad_d = mid_q.bad || (sum > {2'b0, mid_q.limit});
    if (bad_d)          millideg_d = 20'd0;
    else if (mid_q.neg) millideg_d = 20'd0 - sum[19:0];
    else                millideg_d = sum[19:0];
  end

  // Stage valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mid_valid_q <= 1'b0;
      res_valid_q <= 1'b0;
    end else if (adv_i) begin
      mid_valid_q <= snap_valid_i;
      res_valid_q <= mid_valid_q;
    end
  end

  // Stage payloads
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      mid_q      <= mid_d;
      millideg_q <= millideg_d;
      bad_q      <= bad_d;
    end
  end

  assign res_valid_o = res_valid_q;
  assign millideg_o  = millideg_q;
  assign bad_o       = bad_q;

endmodule
